### design/cda_pkg.sv
// shared types, constants and calendar helpers for the date adder
`default_nettype none
package cda_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int ADDY_W  = 14;
  localparam int ADDM_W  = 12;
  localparam int ADDD_W  = 16;

  localparam int DEF_ADD_DAYS_MAX = 65535;

  localparam logic [YEAR_W-1:0]  YEAR_LIMIT = 14'd9999;
  localparam logic [MONTH_W-1:0] DEC_MONTH  = 4'd12;
  localparam logic [DAY_W-1:0]   DEC_DAY    = 5'd31;
  localparam int MONTHS      = 12;
  localparam int YEAR_CYCLE  = 400;
  localparam int CENTURY     = 100;

  // month offset width, working year width, reciprocal of twelve
  localparam int M0_W       = 13;
  localparam int YW_W       = 16;
  localparam int RECIP_SH   = 16;
  localparam int PROD_W     = 2 * M0_W;
  localparam int Q_W        = PROD_W - RECIP_SH;
  localparam logic [M0_W-1:0] RECIP12 = 13'd5462;

  typedef struct packed {
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [ADDY_W-1:0]  add_years;
    logic [ADDM_W-1:0]  add_months;
    logic [ADDD_W-1:0]  add_days;
  } in_item_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  result_year;
    logic [MONTH_W-1:0] result_month;
    logic [DAY_W-1:0]   result_day;
    logic               range_error;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic reduce;
    logic check;
    logic sum;
    logic roll;
    logic emit;
  } cda_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rem_big;
    logic err;
    logic roll_done;
  } cda_stat_t;

  // leap test on a year already reduced modulo 400
  function automatic logic leap_of(input logic [8:0] rem);
    logic zero4;
    zero4 = (rem[1:0] == 2'b00);
    return (zero4 && (rem != 9'(CENTURY)) && (rem != 9'(2 * CENTURY)) &&
            (rem != 9'(3 * CENTURY))) || (rem == 9'd0);
  endfunction

  // days in a month; codes outside 1..12 read as 31
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

### design/calendar_date_add_core.sv
// top level of the gregorian date adder
//
// usage: drive in_item and raise start; the item is taken at an edge where
// start is high and busy is low. busy rises the cycle after and stays high
// until the result is ready. the result item appears on out_item for exactly
// one cycle with out_valid high; the receiver cannot stall, so it must take
// it in that cycle. busy is low again in that cycle, so a new item may be
// started while the result is shown.
// steps: the start year is reduced modulo 400, one step of 400 at a time; the
// start day is checked against its month length; the years and months are
// summed; the summed year is reduced modulo 400 again; the day count is then
// rolled one month per cycle until it fits the current month; the day roll
// loop dominates the time taken. items do not overlap: a new item is taken
// only once the previous one has reached its result.
// an invalid start date or a year past 9999 ends the item early with
// range_error set and the result 9999-12-31.
// reset (synchronous, active low) returns the controller to idle and drops
// out_valid; no item in flight survives reset.
`default_nettype none
module calendar_date_add_core
  import cda_pkg::*;
#(
  parameter int ADD_DAYS_MAX = DEF_ADD_DAYS_MAX
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_item,
  output out_item_t     out_item,
  output logic          out_valid
);

  cda_cmd_t  cmd;
  cda_stat_t stat;

  // sequencer
  cda_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // arithmetic
  cda_datapath #(
    .ADD_DAYS_MAX (ADD_DAYS_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_item  (out_item),
    .out_valid (out_valid)
  );

  // result strobe only shows while idle
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // saturated date on error
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.range_error) |->
      (out_item.result_year == YEAR_LIMIT && out_item.result_month == DEC_MONTH &&
       out_item.result_day == DEC_DAY))
    else $error("error result not saturated");

  // an accepted item makes the block busy
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // valid result month and day otherwise
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.range_error) |->
      (out_item.result_month != 4'd0 && out_item.result_month <= DEC_MONTH &&
       out_item.result_day != 5'd0 && out_item.result_year <= YEAR_LIMIT))
    else $error("result date out of range");

endmodule
`default_nettype wire

### design/cda_ctrl.sv
// sequencing state machine of the date adder
`default_nettype none
module cda_ctrl
  import cda_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire cda_stat_t stat,
  output cda_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_RED0, S_CHK, S_SUM, S_RED1, S_ROLL, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_RED0;
      S_RED0: if (!stat.rem_big) state_nxt = S_CHK;
      S_CHK:  state_nxt = S_SUM;
      S_SUM:  state_nxt = stat.err ? S_OUT : S_RED1;
      S_RED1: begin
        if (stat.err) state_nxt = S_OUT;
        else if (!stat.rem_big) state_nxt = S_ROLL;
      end
      S_ROLL: if (stat.err || stat.roll_done) state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    cmd        = '0;
    cmd.load   = (state_r == S_IDLE) && start;
    cmd.reduce = (state_r == S_RED0) || (state_r == S_RED1);
    cmd.check  = (state_r == S_CHK);
    cmd.sum    = (state_r == S_SUM) && !stat.err;
    cmd.roll   = (state_r == S_ROLL);
    cmd.emit   = (state_r == S_OUT);
  end

  // state and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule
`default_nettype wire

### design/cda_datapath.sv
// date registers, modulo reduction, month split and day roll
`default_nettype none
module cda_datapath
  import cda_pkg::*;
#(
  parameter int ADD_DAYS_MAX = DEF_ADD_DAYS_MAX
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_item_t in_item,
  input  wire cda_cmd_t cmd,
  output cda_stat_t     stat,
  output out_item_t     out_item,
  output logic          out_valid
);

  localparam int DSUM_W = $clog2(ADD_DAYS_MAX + 32);
  localparam int CMP_W  = (DSUM_W > ADDD_W) ? DSUM_W : ADDD_W;

  logic [YW_W-1:0]    y_r;
  logic [ADDY_W-1:0]  ay_r;
  logic [MONTH_W-1:0] m_r;
  logic [DAY_W-1:0]   sd_r;
  logic [M0_W-1:0]    m0_r;
  logic [DSUM_W-1:0]  d_r;
  logic [YW_W-1:0]    rem_r;
  logic [PROD_W-1:0]  prod_r;
  logic               err_r;
  out_item_t          out_item_r;
  logic               out_valid_r;

  logic [CMP_W-1:0]   ad_wide, ad_sat;
  logic               fmt_bad;
  logic               leap;
  logic [DAY_W-1:0]   mlen;
  logic [Q_W-1:0]     q;
  logic [YW_W-1:0]    ysum;
  logic [M0_W-1:0]    mrem;

  // day count saturation and start-date format check
  always_comb begin
    ad_wide = CMP_W'(in_item.add_days);
    ad_sat  = (ad_wide > CMP_W'(ADD_DAYS_MAX)) ? CMP_W'(ADD_DAYS_MAX) : ad_wide;
    fmt_bad = (in_item.start_year > YEAR_LIMIT) || (in_item.start_month == 4'd0) ||
              (in_item.start_month > 4'(MONTHS)) || (in_item.start_day == 5'd0);
  end

  // current month length from reduced year
  always_comb begin
    leap = leap_of(rem_r[8:0]);
    mlen = month_len(m_r, leap);
  end

  // month offset split into years and month
  always_comb begin
    q    = prod_r[PROD_W-1:RECIP_SH];
    ysum = y_r + YW_W'(ay_r) + YW_W'(q);
    mrem = m0_r - M0_W'(M0_W'(q) * M0_W'(MONTHS));
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      y_r   <= YW_W'(in_item.start_year);
      ay_r  <= in_item.add_years;
      m_r   <= in_item.start_month;
      sd_r  <= in_item.start_day;
      m0_r  <= M0_W'(in_item.start_month) - M0_W'(1) + M0_W'(in_item.add_months);
      d_r   <= DSUM_W'(ad_sat) + DSUM_W'(in_item.start_day);
      rem_r <= YW_W'(in_item.start_year);
      err_r <= fmt_bad;
    end
    if (cmd.reduce && (rem_r >= YW_W'(YEAR_CYCLE))) begin
      rem_r <= rem_r - YW_W'(YEAR_CYCLE);
    end
    if (cmd.check) begin
      if (sd_r > mlen) err_r <= 1'b1;
      prod_r <= PROD_W'(m0_r) * PROD_W'(RECIP12);
    end
    if (cmd.sum) begin
      y_r   <= ysum;
      rem_r <= ysum;
      m_r   <= mrem[MONTH_W-1:0] + 4'd1;
      if (ysum > YW_W'(YEAR_LIMIT)) err_r <= 1'b1;
    end
    if (cmd.roll && !err_r && (d_r > DSUM_W'(mlen))) begin
      d_r <= d_r - DSUM_W'(mlen);
      if (m_r == 4'(MONTHS)) begin
        m_r   <= 4'd1;
        y_r   <= y_r + YW_W'(1);
        rem_r <= (rem_r == YW_W'(YEAR_CYCLE - 1)) ? '0 : rem_r + YW_W'(1);
        if (y_r == YW_W'(YEAR_LIMIT)) err_r <= 1'b1;
      end else begin
        m_r <= m_r + 4'd1;
      end
    end
    if (cmd.emit) begin
      out_item_r.range_error <= err_r;
      if (err_r) begin
        out_item_r.result_year  <= YEAR_LIMIT;
        out_item_r.result_month <= DEC_MONTH;
        out_item_r.result_day   <= DEC_DAY;
      end else begin
        out_item_r.result_year  <= y_r[YEAR_W-1:0];
        out_item_r.result_month <= m_r;
        out_item_r.result_day   <= d_r[DAY_W-1:0];
      end
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= cmd.emit;
  end

  // status to controller
  always_comb begin
    stat.rem_big   = (rem_r >= YW_W'(YEAR_CYCLE));
    stat.err       = err_r;
    stat.roll_done = (d_r <= DSUM_W'(mlen));
  end

  assign out_item  = out_item_r;
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire
